// ===== src/hmt_pkg.sv =====
// ----------------------------------------------------------------------------
// hmt_pkg
// Shared constants for the heartbeat membership table: defaults, field
// widths, item kinds, event codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package hmt_pkg;

  localparam int HMT_TABLE_DEPTH = 32;
  localparam int HMT_ID_BITS     = 16;

  localparam int KIND_W  = 2;
  localparam int EID_W   = 16;
  localparam int BEAT_W  = 32;
  localparam int STAMP_W = 32;
  localparam int RES_W   = 3;
  localparam int ECNT_W  = 6;
  localparam int IN_DW   = EID_W + BEAT_W + STAMP_W;
  localparam int OUT_DW  = 24;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEAT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MERGE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_JOIN  = 2'd3;

  localparam logic [RES_W-1:0] EV_NOTHING   = 3'd0;
  localparam logic [RES_W-1:0] EV_ADDED     = 3'd1;
  localparam logic [RES_W-1:0] EV_UPDATED   = 3'd2;
  localparam logic [RES_W-1:0] EV_UNCHANGED = 3'd3;
  localparam logic [RES_W-1:0] EV_REMOVED   = 3'd4;
  localparam logic [RES_W-1:0] EV_FULL      = 3'd5;
  localparam logic [RES_W-1:0] EV_STALE     = 3'd6;

  localparam logic REG_OWN_ID       = 1'b0;
  localparam logic REG_FAIL_TIMEOUT = 1'b1;

  localparam logic [15:0] FAIL_TIMEOUT_RST = 16'd5;

endpackage

`default_nettype wire

// ===== src/hmt_ram.sv =====
// ----------------------------------------------------------------------------
// hmt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/heartbeat_membership_table.sv =====
// ----------------------------------------------------------------------------
// heartbeat_membership_table
// Membership table of a heartbeat failure detector: ticks expire stale
// entries, updates and merge elements refresh or insert, joins append.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  in_      | slave     | in_tvalid / in_tready   | tuser kind, tdata id/beat/stamp
//  out_     | master    | out_tvalid / out_tready | tuser event, tdata id/count, tlast
//  cfg_     | APB slave | psel, penable, pready   | own_id @0x0, fail_timeout @0x4
//
// Each transaction passes through the accept cycle, one slot-table RAM
// read per slot, a drain of the last read and a final read-modify-write
// cycle. A tick that expires several entries holds its scan while the
// result register is full and unread.
// The next transaction is accepted while the last result still waits.
// Reset clears the valid bits, local time and count; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module heartbeat_membership_table import hmt_pkg::*; #(
  parameter int TABLE_DEPTH = HMT_TABLE_DEPTH,
  parameter int ID_BITS     = HMT_ID_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [IN_DW-1:0]   in_tdata,   // entry_id[15:0], beat[47:16], stamp[79:48]
  input  wire logic [KIND_W-1:0]  in_tuser,   // kind[1:0]
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [OUT_DW-1:0]  out_tdata,  // event_id[15:0], entry_count[21:16], zero
  output logic      [RES_W-1:0]   out_tuser,  // event_res[2:0]
  output logic                    out_tlast,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [2:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic      [31:0]        cfg_prdata,
  output logic                    cfg_pready
);

  localparam int NODE_W = (ID_BITS < EID_W) ? ID_BITS : EID_W;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int MEM_W  = NODE_W + BEAT_W + STAMP_W;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  function automatic logic [EID_W-1:0] id_ext(input logic [NODE_W-1:0] v);
    logic [NODE_W+EID_W-1:0] t;
    t = {{EID_W{1'b0}}, v};
    return t[EID_W-1:0];
  endfunction

  function automatic logic [ECNT_W-1:0] cnt_ext(input logic [CNT_W-1:0] v);
    logic [CNT_W+ECNT_W-1:0] t;
    t = {{ECNT_W{1'b0}}, v};
    return t[ECNT_W-1:0];
  endfunction

  logic [1:0]             state_r, state_nxt;
  logic [KIND_W-1:0]      kind_r;
  logic [NODE_W-1:0]      id_r;
  logic [BEAT_W-1:0]      beat_r;
  logic [STAMP_W-1:0]     stamp_r;
  logic [31:0]            lt_r, lt_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [15:0]            own_r, fto_r;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       ra_r, ra_nxt;
  logic                   dv_r, dv_nxt;
  logic [IDX_W-1:0]       di_r, di_nxt;
  logic                   fnd_r, fnd_nxt;
  logic [IDX_W-1:0]       fidx_r, fidx_nxt;
  logic [BEAT_W-1:0]      fbeat_r, fbeat_nxt;
  logic                   free_v_r, free_v_nxt;
  logic [IDX_W-1:0]       free_idx_r, free_idx_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [NODE_W-1:0]      pend_id_r, pend_id_nxt;
  logic [CNT_W-1:0]       pend_cnt_r, pend_cnt_nxt;
  logic                   out_valid_r;
  logic [RES_W-1:0]       out_res_r;
  logic [EID_W-1:0]       out_id_r;
  logic [ECNT_W-1:0]      out_cnt_r;
  logic                   out_last_r;

  logic                   ld;
  logic [RES_W-1:0]       ld_res;
  logic [EID_W-1:0]       ld_id;
  logic [ECNT_W-1:0]      ld_cnt;
  logic                   ld_last;

  logic                   wr_en, rd_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [MEM_W-1:0]       wr_data, rd_data;
  logic [NODE_W-1:0]      rd_node;
  logic [BEAT_W-1:0]      rd_beat;
  logic [STAMP_W-1:0]     rd_seen;

  logic                   in_acc, out_free, cfg_wr;
  logic [NODE_W-1:0]      own_m;
  logic [31:0]            age, age_in, fto32;
  logic                   slot_v, is_own, expire, rm, own_wr, match, stall, adv;
  logic                   fresh, do_upd, do_ins;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign own_m    = own_r[NODE_W-1:0];
  assign fto32    = {16'd0, fto_r};
  assign rd_node  = rd_data[MEM_W-1 -: NODE_W];
  assign rd_beat  = rd_data[BEAT_W+STAMP_W-1 -: BEAT_W];
  assign rd_seen  = rd_data[STAMP_W-1:0];

  // slot inspection during the scan
  assign slot_v = valid_r[di_r];
  assign is_own = rd_node == own_m;
  assign age    = lt_r - rd_seen;
  assign expire = slot_v && !is_own && !age[31] && (age > fto32);
  assign rm     = dv_r && (kind_r == KIND_TICK) && expire;
  assign own_wr = dv_r && (kind_r == KIND_TICK) && slot_v && is_own;
  assign match  = dv_r && slot_v && (rd_node == id_r);
  assign stall  = rm && pend_v_r && !out_free;
  assign adv    = (state_r == S_SCAN) && !stall;
  assign rd_en  = adv && (ra_r != CNT_END);

  // final decision for update, merge and join
  assign age_in = lt_r - stamp_r;
  assign fresh  = age_in[31] || (age_in < fto32);
  assign do_upd = (kind_r != KIND_JOIN) && (kind_r != KIND_TICK) && fnd_r &&
                  (fbeat_r < beat_r);
  assign do_ins = (kind_r == KIND_JOIN) ||
                  (!fnd_r && ((kind_r == KIND_BEAT) ||
                              ((kind_r == KIND_MERGE) && fresh)));

  always_comb begin
    state_nxt    = state_r;
    lt_nxt       = lt_r;
    cnt_nxt      = cnt_r;
    valid_nxt    = valid_r;
    ra_nxt       = ra_r;
    dv_nxt       = dv_r;
    di_nxt       = di_r;
    fnd_nxt      = fnd_r;
    fidx_nxt     = fidx_r;
    fbeat_nxt    = fbeat_r;
    free_v_nxt   = free_v_r;
    free_idx_nxt = free_idx_r;
    pend_v_nxt   = pend_v_r;
    pend_id_nxt  = pend_id_r;
    pend_cnt_nxt = pend_cnt_r;
    ld           = 1'b0;
    ld_res       = EV_NOTHING;
    ld_id        = '0;
    ld_cnt       = cnt_ext(cnt_r);
    ld_last      = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = di_r;
    wr_data      = {rd_node, rd_beat, lt_r};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt  = S_SCAN;
          ra_nxt     = '0;
          dv_nxt     = 1'b0;
          fnd_nxt    = 1'b0;
          free_v_nxt = 1'b0;
          pend_v_nxt = 1'b0;
          if (in_tuser == KIND_TICK) begin
            lt_nxt = lt_r + 32'd1;
          end
        end
      end
      S_SCAN: begin
        if (adv) begin
          if (ra_r != CNT_END) begin
            ra_nxt = ra_r + CNT_ONE;
            dv_nxt = 1'b1;
            di_nxt = ra_r[IDX_W-1:0];
          end else begin
            dv_nxt    = 1'b0;
            state_nxt = S_FIN;
          end
          if (match && !fnd_r) begin
            fnd_nxt   = 1'b1;
            fidx_nxt  = di_r;
            fbeat_nxt = rd_beat;
          end
          if (dv_r && !slot_v && !free_v_r) begin
            free_v_nxt   = 1'b1;
            free_idx_nxt = di_r;
          end
          if (own_wr) begin
            wr_en = 1'b1;
          end
          if (rm) begin
            valid_nxt[di_r] = 1'b0;
            cnt_nxt         = cnt_r - CNT_ONE;
            pend_v_nxt      = 1'b1;
            pend_id_nxt     = rd_node;
            pend_cnt_nxt    = cnt_r - CNT_ONE;
            if (pend_v_r) begin
              ld     = 1'b1;
              ld_res = EV_REMOVED;
              ld_id  = id_ext(pend_id_r);
              ld_cnt = cnt_ext(pend_cnt_r);
            end
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          ld        = 1'b1;
          ld_last   = 1'b1;
          if (kind_r == KIND_TICK) begin
            pend_v_nxt = 1'b0;
            if (pend_v_r) begin
              ld_res = EV_REMOVED;
              ld_id  = id_ext(pend_id_r);
              ld_cnt = cnt_ext(pend_cnt_r);
            end
          end else begin
            ld_id = id_ext(id_r);
            if (do_upd) begin
              ld_res  = EV_UPDATED;
              wr_en   = 1'b1;
              wr_addr = fidx_r;
              wr_data = {id_r, beat_r, (kind_r == KIND_BEAT) ? lt_r : stamp_r};
            end else if (do_ins) begin
              if (free_v_r) begin
                ld_res                = EV_ADDED;
                wr_en                 = 1'b1;
                wr_addr               = free_idx_r;
                wr_data               = {id_r, beat_r, stamp_r};
                valid_nxt[free_idx_r] = 1'b1;
                cnt_nxt               = cnt_r + CNT_ONE;
                ld_cnt                = cnt_ext(cnt_r + CNT_ONE);
              end else begin
                ld_res = EV_FULL;
              end
            end else if (fnd_r) begin
              ld_res = EV_UNCHANGED;
            end else begin
              ld_res = EV_STALE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lt_r        <= '0;
      cnt_r       <= '0;
      valid_r     <= '0;
      dv_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      own_r       <= '0;
      fto_r       <= FAIL_TIMEOUT_RST;
    end else begin
      state_r  <= state_nxt;
      lt_r     <= lt_nxt;
      cnt_r    <= cnt_nxt;
      valid_r  <= valid_nxt;
      dv_r     <= dv_nxt;
      pend_v_r <= pend_v_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_OWN_ID) begin
          own_r <= cfg_pwdata[15:0];
        end else begin
          fto_r <= cfg_pwdata[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ra_r       <= ra_nxt;
    di_r       <= di_nxt;
    fnd_r      <= fnd_nxt;
    fidx_r     <= fidx_nxt;
    fbeat_r    <= fbeat_nxt;
    free_v_r   <= free_v_nxt;
    free_idx_r <= free_idx_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    if (in_acc) begin
      kind_r  <= in_tuser;
      id_r    <= in_tdata[NODE_W-1:0];
      beat_r  <= in_tdata[EID_W +: BEAT_W];
      stamp_r <= in_tdata[EID_W+BEAT_W +: STAMP_W];
    end
    if (ld) begin
      out_res_r  <= ld_res;
      out_id_r   <= ld_id;
      out_cnt_r  <= ld_cnt;
      out_last_r <= ld_last;
    end
  end

  hmt_ram #(
    .WIDTH (MEM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ra_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_id_r};
  assign out_tuser  = out_res_r;
  assign out_tlast  = out_last_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FAIL_TIMEOUT) ? {16'd0, fto_r} : {16'd0, own_r};

endmodule

`default_nettype wire

// ===== src/hmt_checker.sv =====
// ----------------------------------------------------------------------------
// hmt_checker
// Port-level checks for the heartbeat membership table, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module hmt_checker import hmt_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic [RES_W-1:0]  out_tuser,
  input wire logic              out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // single-result transactions always close the run
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EV_ADDED || out_tuser == EV_UPDATED ||
      out_tuser == EV_UNCHANGED || out_tuser == EV_FULL || out_tuser == EV_STALE)
      |-> out_tlast)
    else $error("single result without tlast");

  // an empty tick reports id zero and closes the run
  a_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EV_NOTHING) |-> out_tlast && (out_tdata[15:0] == 16'd0))
    else $error("malformed nothing result");

  // no result right out of reset
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

  // no new transaction accepted while a tick run is still open at the output
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |-> !(in_tvalid && in_tready))
    else $error("transaction accepted during an open result run");

endmodule

bind heartbeat_membership_table hmt_checker u_hmt_checker (.*);

`default_nettype wire
